FILE: hw/rtl/date_sorted_record_table_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the date sorted record table
// Shared clocked, reset-gated assertion forms.
// ----------------------------------------------------------------------------
`ifndef DATE_SORTED_RECORD_TABLE_TOP_DEFINES_SVH
`define DATE_SORTED_RECORD_TABLE_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define DSRT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset
`define DSRT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/dsrt_pkg.sv
// ----------------------------------------------------------------------------
// dsrt_pkg
// Types, codes and sizes for the date sorted record table.
// ----------------------------------------------------------------------------
package dsrt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int DATE_W      = 23;
	localparam int ID_W        = 32;

	// Command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;
	localparam logic [1:0] CMD_RANGE  = 2'd3;

	// Status codes
	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_FOUND    = 2'd1;
	localparam logic [1:0] ST_NOMATCH  = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_PLACE,
		S_FIN
	} state_t;

	// One stored record
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [DATE_W-1:0] date;
	} entry_t;

	// One result word
	typedef struct packed {
		logic [1:0]        status;
		logic [ID_W-1:0]   id;
		logic [DATE_W-1:0] date;
		logic [3:0]        pos;
		logic [4:0]        count;
		logic              last;
	} result_t;

endpackage

FILE: hw/rtl/date_sorted_record_table_top.sv
// ----------------------------------------------------------------------------
// date_sorted_record_table_top
// Record table kept in descending date order in a single-port-read memory.
// ----------------------------------------------------------------------------
//  channel | signals                         | words
//  in      | in_valid/in_ready + 8 fields    | one command
//  out     | out_valid/out_ready + 8 fields  | 1..16 results per command
//
//  A command makes at most one memory read per stored record in a single scan,
//  with shifts written back during that scan.
//  Reset clears the record count and control; memory contents need none.
//  The scan halts while a range-delete result waits on a busy output.
//  A new command is taken while the final result waits in the output register.
// ----------------------------------------------------------------------------
`include "date_sorted_record_table_top_defines.svh"

module date_sorted_record_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [31:0] entry_id,
	input  logic [4:0]  date_day,
	input  logic [3:0]  date_month,
	input  logic [13:0] date_year,
	input  logic [4:0]  upper_day,
	input  logic [3:0]  upper_month,
	input  logic [13:0] upper_year,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] out_id,
	output logic [4:0]  out_day,
	output logic [3:0]  out_month,
	output logic [13:0] out_year,
	output logic [3:0]  out_position,
	output logic [4:0]  entry_count,
	output logic        last
);
	import dsrt_pkg::*;

	// Record memory
	entry_t mem [TABLE_DEPTH];
	entry_t rd_q;

	state_t state_q, state_d;

	logic [1:0]        cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [DATE_W-1:0] lo_q, hi_q;
	logic [CNT_W-1:0]  total_q, total_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  rem_q, rem_d;
	logic              found_q, found_d;
	result_t           res_q, res_d;
	result_t           out_q, out_d;
	logic              out_valid_q;

	logic              rd_en, wr_en, out_load;
	logic [IDX_W-1:0]  rd_addr, wr_addr;
	entry_t            wr_data;
	logic              go_fin, go_place, go_scan;

	logic              out_free, last_idx, match, hit, ins_shift;
	logic [CNT_W-1:0]  rem_inc;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign last_idx = (({1'b0, idx_q} + 1'b1) == total_q);
	assign match    = (rd_q.id == id_q);
	assign hit      = (rd_q.date >= lo_q) && (rd_q.date <= hi_q);
	assign rem_inc  = rem_q + 1'b1;
	// Shift the record one slot down for an insert scan
	assign ins_shift = (idx_q != '0) ? (rd_q.date <= lo_q) : (lo_q > rd_q.date);

	// Datapath and memory control
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = rd_q;
		out_load = 1'b0;
		out_d    = res_q;
		total_d  = total_q;
		idx_d    = idx_q;
		rem_d    = rem_q;
		found_d  = found_q;
		res_d    = res_q;
		go_fin   = 1'b0;
		go_place = 1'b0;
		go_scan  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_START: begin
				rem_d   = '0;
				found_d = 1'b0;
				res_d   = '{ST_NOMATCH, '0, '0, '0, total_q, 1'b1};
				if (cmd_q == CMD_INSERT) begin
					if (total_q == CNT_W'(TABLE_DEPTH)) begin
						res_d  = '{ST_FULL, '0, '0, '0, total_q, 1'b1};
						go_fin = 1'b1;
					end else if (total_q == '0) begin
						idx_d    = '0;
						go_place = 1'b1;
					end else begin
						idx_d   = IDX_W'(total_q - 1'b1);
						rd_en   = 1'b1;
						rd_addr = idx_d;
						go_scan = 1'b1;
					end
				end else if (total_q == '0) begin
					go_fin = 1'b1;
				end else begin
					idx_d   = '0;
					rd_en   = 1'b1;
					rd_addr = '0;
					go_scan = 1'b1;
				end
			end
			S_SCAN: begin
				unique case (cmd_q)
					CMD_INSERT: begin
						if (ins_shift) begin
							wr_en   = 1'b1;
							wr_addr = idx_q + 1'b1;
							if (idx_q != '0) begin
								idx_d   = idx_q - 1'b1;
								rd_en   = 1'b1;
								rd_addr = idx_d;
							end else begin
								go_place = 1'b1;
							end
						end else begin
							idx_d    = idx_q + 1'b1;
							go_place = 1'b1;
						end
					end
					CMD_SEARCH: begin
						if (match) begin
							res_d  = '{ST_FOUND, rd_q.id, rd_q.date, idx_q, total_q, 1'b1};
							go_fin = 1'b1;
						end else if (last_idx) begin
							go_fin = 1'b1;
						end else begin
							idx_d   = idx_q + 1'b1;
							rd_en   = 1'b1;
							rd_addr = idx_d;
						end
					end
					CMD_DELETE: begin
						// close the gap behind the removed record
						if (found_q) begin
							wr_en   = 1'b1;
							wr_addr = idx_q - 1'b1;
						end else if (match) begin
							found_d = 1'b1;
							res_d   = '{ST_FOUND, rd_q.id, rd_q.date, idx_q,
								total_q - 1'b1, 1'b1};
						end
						if (last_idx) begin
							if (found_d) total_d = total_q - 1'b1;
							go_fin = 1'b1;
						end else begin
							idx_d   = idx_q + 1'b1;
							rd_en   = 1'b1;
							rd_addr = idx_d;
						end
					end
					CMD_RANGE: begin
						// hold one result back so the final one carries last
						if (!(hit && found_q && !out_free)) begin
							if (hit) begin
								if (found_q) begin
									out_load   = 1'b1;
									out_d      = res_q;
									out_d.last = 1'b0;
								end
								res_d   = '{ST_FOUND, rd_q.id, rd_q.date,
									IDX_W'({1'b0, idx_q} - rem_q),
									total_q - rem_inc, 1'b1};
								found_d = 1'b1;
								rem_d   = rem_inc;
							end else begin
								wr_en   = 1'b1;
								wr_addr = IDX_W'({1'b0, idx_q} - rem_q);
							end
							if (last_idx) begin
								total_d = total_q - rem_d;
								if (!found_d) begin
									res_d = '{ST_NOMATCH, '0, '0, '0, total_d, 1'b1};
								end
								go_fin = 1'b1;
							end else begin
								idx_d   = idx_q + 1'b1;
								rd_en   = 1'b1;
								rd_addr = idx_d;
							end
						end
					end
					default: begin
					end
				endcase
			end
			S_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = '{id_q, lo_q};
				total_d = total_q + 1'b1;
				res_d   = '{ST_INSERTED, '0, '0, idx_q, total_d, 1'b1};
				go_fin  = 1'b1;
			end
			S_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d    = res_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_d = S_START;
			S_START: begin
				if (go_fin) state_d = S_FIN;
				else if (go_place) state_d = S_PLACE;
				else if (go_scan) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (go_fin) state_d = S_FIN;
				else if (go_place) state_d = S_PLACE;
			end
			S_PLACE: state_d = S_FIN;
			S_FIN:   if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			found_q     <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			total_q <= total_d;
			found_q <= found_d;
			rem_q   <= rem_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= command;
			id_q  <= entry_id;
			lo_q  <= {date_year, date_month, date_day};
			hi_q  <= {upper_year, upper_month, upper_day};
		end
		idx_q <= idx_d;
		res_q <= res_d;
		if (out_load) out_q <= out_d;
	end

	// Record memory ports
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign out_id       = out_q.id;
	assign out_day      = out_q.date[4:0];
	assign out_month    = out_q.date[8:5];
	assign out_year     = out_q.date[22:9];
	assign out_position = out_q.pos;
	assign entry_count  = out_q.count;
	assign last         = out_q.last;

	// Checks
	`DSRT_ASSERT(a_total_bound, total_q <= CNT_W'(TABLE_DEPTH), "record count over depth")
	`DSRT_ASSERT_IMP(a_scan_idx, state_q == S_SCAN, {1'b0, idx_q} < total_q, "scan past end")
	`DSRT_ASSERT(a_no_rw_clash, !(wr_en && rd_en && wr_addr == rd_addr), "read-write clash")

endmodule

FILE: verif/date_sorted_record_table_top_tb.sv
// ----------------------------------------------------------------------------
// Date sorted record table testbench
// Drives insert, search, delete and range-delete commands through the input
// handshake, predicts every result word from a model of the table kept in
// descending date order, and compares each output word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module date_sorted_record_table_top_tb;
	import dsrt_pkg::*;

	typedef struct {
		logic [1:0]  cmd;
		logic [31:0] id;
		logic [4:0]  lo_d;
		logic [3:0]  lo_m;
		logic [13:0] lo_y;
		logic [4:0]  hi_d;
		logic [3:0]  hi_m;
		logic [13:0] hi_y;
	} cmd_word_t;

	typedef struct {
		logic [1:0]  st;
		logic [31:0] id;
		logic [4:0]  d;
		logic [3:0]  m;
		logic [13:0] y;
		logic [3:0]  pos;
		logic [4:0]  cnt;
		logic        fin;
	} res_word_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0]  command, status;
	logic [31:0] entry_id, out_id;
	logic [4:0]  date_day, upper_day, out_day, entry_count;
	logic [3:0]  date_month, upper_month, out_month, out_position;
	logic [13:0] date_year, upper_year, out_year;
	logic last;

	date_sorted_record_table_top u_top (.*);

	cmd_word_t pending_cmds[$];
	res_word_t expected_results[$];

	// Shadow table
	logic [31:0] tbl_id[TABLE_DEPTH];
	logic [22:0] tbl_date[TABLE_DEPTH];
	int          tbl_cnt;

	int errors;
	int send_idle_pct, recv_stall_pct;
	bit recv_hold;
	int results_seen;
	logic [31:0] known_ids[$];

	function automatic res_word_t mk_res(logic [1:0] st, logic [31:0] id,
			logic [22:0] dt, int pos, logic fin);
		res_word_t r;
		r.st = st; r.id = id; r.d = dt[4:0]; r.m = dt[8:5]; r.y = dt[22:9];
		r.pos = pos[3:0]; r.cnt = tbl_cnt[4:0]; r.fin = fin;
		return r;
	endfunction

	function automatic void drop_record(int p);
		for (int i = p; i + 1 < tbl_cnt; i++) begin
			tbl_id[i] = tbl_id[i+1];
			tbl_date[i] = tbl_date[i+1];
		end
		tbl_cnt--;
	endfunction

	// Update the shadow table and queue the result words of one command
	function automatic void predict_table(cmd_word_t c);
		logic [22:0] lo, hi, dt;
		logic [31:0] rid;
		int p, n;
		lo = {c.lo_y, c.lo_m, c.lo_d};
		hi = {c.hi_y, c.hi_m, c.hi_d};
		case (c.cmd)
			CMD_INSERT: begin
				if (tbl_cnt >= TABLE_DEPTH) begin
					expected_results.push_back(mk_res(ST_FULL, 0, 0, 0, 1));
				end else begin
					// tie with the head lands just after the head
					if (tbl_cnt == 0 || lo > tbl_date[0]) p = 0;
					else begin
						p = 1;
						while (p < tbl_cnt && tbl_date[p] > lo) p++;
					end
					for (int i = tbl_cnt; i > p; i--) begin
						tbl_id[i] = tbl_id[i-1];
						tbl_date[i] = tbl_date[i-1];
					end
					tbl_id[p] = c.id;
					tbl_date[p] = lo;
					tbl_cnt++;
					expected_results.push_back(mk_res(ST_INSERTED, 0, 0, p, 1));
				end
			end
			CMD_SEARCH, CMD_DELETE: begin
				p = -1;
				for (int i = 0; i < tbl_cnt; i++)
					if (p < 0 && tbl_id[i] == c.id) p = i;
				if (p < 0) begin
					expected_results.push_back(mk_res(ST_NOMATCH, 0, 0, 0, 1));
				end else begin
					rid = tbl_id[p];
					dt = tbl_date[p];
					if (c.cmd == CMD_DELETE) drop_record(p);
					expected_results.push_back(mk_res(ST_FOUND, rid, dt, p, 1));
				end
			end
			default: begin
				n = 0;
				forever begin
					p = -1;
					for (int i = 0; i < tbl_cnt; i++)
						if (p < 0 && tbl_date[i] >= lo && tbl_date[i] <= hi) p = i;
					if (p < 0) break;
					rid = tbl_id[p];
					dt = tbl_date[p];
					drop_record(p);
					expected_results.push_back(mk_res(ST_FOUND, rid, dt, p, 0));
					n++;
				end
				if (n == 0)
					expected_results.push_back(mk_res(ST_NOMATCH, 0, 0, 0, 1));
				else
					expected_results[$].fin = 1;
			end
		endcase
	endfunction

	// Clock and reset
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
	end

	// Driver: offer the next queued word, hold it until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			{command, entry_id, date_day, date_month, date_year} <= '0;
			{upper_day, upper_month, upper_year} <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) predict_table(pending_cmds.pop_front());
			if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1;
				command <= pending_cmds[0].cmd;
				entry_id <= pending_cmds[0].id;
				date_day <= pending_cmds[0].lo_d;
				date_month <= pending_cmds[0].lo_m;
				date_year <= pending_cmds[0].lo_y;
				upper_day <= pending_cmds[0].hi_d;
				upper_month <= pending_cmds[0].hi_m;
				upper_year <= pending_cmds[0].hi_y;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// Monitor: compare each accepted result word with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		res_word_t e;
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result word with none expected");
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (status !== e.st) begin
						$error("status exp %0d got %0d", e.st, status); errors++; end
					if (out_id !== e.id) begin
						$error("out_id exp %h got %h", e.id, out_id); errors++; end
					if (out_day !== e.d) begin
						$error("out_day exp %0d got %0d", e.d, out_day); errors++; end
					if (out_month !== e.m) begin
						$error("out_month exp %0d got %0d", e.m, out_month); errors++; end
					if (out_year !== e.y) begin
						$error("out_year exp %0d got %0d", e.y, out_year); errors++; end
					if (out_position !== e.pos) begin
						$error("out_position exp %0d got %0d", e.pos, out_position);
						errors++;
					end
					if (entry_count !== e.cnt) begin
						$error("entry_count exp %0d got %0d", e.cnt, entry_count);
						errors++;
					end
					if (last !== e.fin) begin
						$error("last exp %0d got %0d", e.fin, last); errors++; end
				end
			end
			out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Command builders
	function automatic logic [31:0] pick_id();
		if (known_ids.size() > 0 && $urandom_range(3) != 0)
			return known_ids[$urandom_range(known_ids.size() - 1)];
		return $urandom_range(7) == 0 ? $urandom : 32'h41414130 + $urandom_range(9);
	endfunction

	task automatic add_cmd(logic [1:0] cmd, logic [31:0] id, logic [22:0] lo,
			logic [22:0] hi);
		cmd_word_t c;
		c.cmd = cmd; c.id = id;
		{c.lo_y, c.lo_m, c.lo_d} = lo;
		{c.hi_y, c.hi_m, c.hi_d} = hi;
		pending_cmds.push_back(c);
		if (cmd == CMD_INSERT) known_ids.push_back(id);
	endtask

	function automatic logic [22:0] rand_date();
		logic [22:0] d;
		case ($urandom_range(5))
			0: d = 23'($urandom);  // raw field values, no validity check
			1: d = {14'd2000, 4'd6, 5'd15};  // frequent ties
			default: d = {14'(1990 + $urandom_range(20)), 4'($urandom_range(1, 12)),
				5'($urandom_range(1, 31))};
		endcase
		return d;
	endfunction

	task automatic add_random(int n);
		logic [22:0] a, b;
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			a = rand_date();
			b = rand_date();
			if (k < 50) add_cmd(CMD_INSERT, pick_id(), a, b);
			else if (k < 68) add_cmd(CMD_SEARCH, pick_id(), a, b);
			else if (k < 86) add_cmd(CMD_DELETE, pick_id(), a, b);
			else if (a <= b || $urandom_range(4) == 0) add_cmd(CMD_RANGE, pick_id(), a, b);
			else add_cmd(CMD_RANGE, pick_id(), b, a);
		end
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	// Stimulus
	initial begin
		logic [22:0] dmin, dmax, dmid;
		errors = 0; results_seen = 0;
		tbl_cnt = 0;
		send_idle_pct = 0; recv_stall_pct = 0; recv_hold = 0;
		dmin = {14'd0, 4'd1, 5'd1};
		dmax = {14'd9999, 4'd12, 5'd31};
		dmid = {14'd2020, 4'd5, 5'd10};
		@(posedge arst_n);

		// Directed: empty-table cases, ordering, ties, full table, ranges
		add_cmd(CMD_SEARCH, 32'h0, dmin, dmax);
		add_cmd(CMD_DELETE, 32'hFFFFFFFF, dmin, dmax);
		add_cmd(CMD_RANGE, 32'h0, dmin, dmax);
		add_cmd(CMD_INSERT, 32'h41424344, dmid, dmid);
		add_cmd(CMD_INSERT, 32'h45464748, dmid, dmid);  // tie with head
		add_cmd(CMD_INSERT, 32'hFFFFFFFF, dmax, dmin);
		add_cmd(CMD_INSERT, 32'h00000000, dmin, dmax);
		add_cmd(CMD_INSERT, 32'h494A4B4C, dmid, dmid);  // tie past the head
		add_cmd(CMD_INSERT, 32'h7FFFFFFF, 23'h7FFFFF, 0);
		for (int i = 0; i < 11; i++)
			add_cmd(CMD_INSERT, 32'h50000000 + i, {14'(2000 + i), 4'd3, 5'd7}, 0);
		add_cmd(CMD_SEARCH, 32'h45464748, 0, 0);
		add_cmd(CMD_DELETE, 32'h41424344, 0, 0);
		add_cmd(CMD_RANGE, 0, dmax, dmin);  // lower above upper
		add_cmd(CMD_RANGE, 0, 0, 23'h7FFFFF);  // clears everything
		wait_drained();

		// Random phases with different idling
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
				3: begin send_idle_pct = 17; recv_stall_pct = 17; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			add_random(21);
			if (ph == 4) begin
				// long receiver hold-off while the sender keeps offering
				fork
					begin
						recv_hold = 1;
						repeat (300) @(posedge clk);
						recv_hold = 0;
					end
				join_none
			end
			wait_drained();  // sender pauses until all results are in
		end

		repeat (60) @(posedge clk);
		$display("Ran %0d results over directed table cases and five random phases",
			results_seen);
		$display("covering insert order, ties, full table, searches and range deletes");
		if (errors == 0 && expected_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog
	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/dsrt_pkg.sv
hw/rtl/date_sorted_record_table_top.sv
verif/date_sorted_record_table_top_tb.sv
